// ===== sv/vmlv_pkg.sv =====
// shared types and constants of the vertex majority label vote block
// no dependencies; imported by vertex_majority_label_vote and the testbench files
`default_nettype none

package vmlv_pkg;

  // fixed field widths of the item, result and configuration beats
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned ID_W       = 12;
  localparam int unsigned LABEL_IN_W = 8;
  localparam int unsigned VCOUNT_W   = 13;
  localparam int unsigned VLABEL_W   = 4;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 13'd4096;

  // corners of one triangle and the step counter that walks them
  localparam int unsigned TRI_CORNERS = 3;
  localparam int unsigned STEP_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } vmlv_req_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_TRI   = 3'd2,
    ST_QLOAD = 3'd3,
    ST_QSCAN = 3'd4
  } vmlv_state_e;

endpackage

`default_nettype wire

// ===== sv/vmlv_row_ram.sv =====
// single port-pair row memory, one write and one registered read per cycle
// depends on nothing; used by vertex_majority_label_vote for the counter rows
`default_nettype none

module vmlv_row_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 256,
  parameter int unsigned AW    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read before write on the same address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/vmlv_row_update.sv =====
// saturating increment of one label counter inside a histogram row
// depends on nothing; used by vertex_majority_label_vote
`default_nettype none

module vmlv_row_update #(
  parameter int unsigned LABEL_COUNT = 16,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned LW          = 4
) (
  input  logic [LABEL_COUNT*COUNT_BITS-1:0] row_i,
  input  logic [LW-1:0]                     label_i,
  output logic [LABEL_COUNT*COUNT_BITS-1:0] row_o
);

  logic [COUNT_BITS-1:0] cnt;

  always_comb begin
    cnt   = row_i[label_i*COUNT_BITS +: COUNT_BITS];
    row_o = row_i;
    // counter stops at all ones
    if (cnt != '1) begin
      row_o[label_i*COUNT_BITS +: COUNT_BITS] = cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vmlv_vote_scan.sv =====
// walks one histogram row a counter per cycle and keeps the first maximum
// depends on nothing; used by vertex_majority_label_vote for queries
`default_nettype none

module vmlv_vote_scan #(
  parameter int unsigned LABEL_COUNT = 16,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned LW          = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [LABEL_COUNT*COUNT_BITS-1:0] row_i,
  output logic                              done_o,
  output logic [LW-1:0]                     label_o
);

  localparam int unsigned RowW = LABEL_COUNT * COUNT_BITS;
  localparam logic [LW-1:0] LastIdx = LW'(LABEL_COUNT - 1);

  logic [RowW-1:0]       row_q;
  logic [COUNT_BITS-1:0] best_cnt_q;
  logic [LW-1:0]         best_q;
  logic [LW-1:0]         idx_q;
  logic                  active_q;
  logic                  done_q;
  logic [COUNT_BITS-1:0] cur;

  assign cur = row_q[COUNT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (load_i) begin
        active_q <= 1'b1;
      end else if (active_q && idx_q == LastIdx) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end
  end

  // strict greater than, so ties stay with the lower label
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q      <= row_i >> COUNT_BITS;
      best_cnt_q <= row_i[COUNT_BITS-1:0];
      best_q     <= '0;
      idx_q      <= LW'(1);
    end else if (active_q) begin
      row_q <= row_q >> COUNT_BITS;
      idx_q <= idx_q + 1'b1;
      if (cur > best_cnt_q) begin
        best_cnt_q <= cur;
        best_q     <= idx_q;
      end
    end
  end

  assign done_o  = done_q;
  assign label_o = best_q;

endmodule

`default_nettype wire

// ===== sv/vertex_majority_label_vote.sv =====
// top level: per-vertex label histograms with majority query
// depends on vmlv_pkg, vmlv_row_ram, vmlv_row_update, vmlv_vote_scan
// add triangle: result strobe after the last corner pass; no new item is taken meanwhile
//   (three read-modify-write passes over the row memory, one corner per cycle)
// query: result once the vote scan has walked the row (one counter compared per cycle)
// rejected triangle, failed query, unused request: result next cycle, no busy
// clear and reset: sweep writing a zero row to each of the MAX_VERTICES rows, busy high throughout
// results cannot be stalled; the configuration port is always ready
`default_nettype none

module vertex_majority_label_vote #(
  parameter int unsigned MAX_VERTICES = 4096,
  parameter int unsigned LABEL_COUNT  = 16,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item channel
  input  logic                           start,
  output logic                           busy,
  input  logic [vmlv_pkg::REQ_W-1:0]     req_type_i,
  input  logic [vmlv_pkg::ID_W-1:0]      vertex_a_i,
  input  logic [vmlv_pkg::ID_W-1:0]      vertex_b_i,
  input  logic [vmlv_pkg::ID_W-1:0]      vertex_c_i,
  input  logic [vmlv_pkg::LABEL_IN_W-1:0] part_label_i,
  input  logic [vmlv_pkg::ID_W-1:0]      query_vertex_i,
  // result channel
  output logic                           result_strobe_o,
  output logic                           accepted_o,
  output logic                           error_seen_o,
  output logic [vmlv_pkg::VLABEL_W-1:0]  vertex_label_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vmlv_pkg::VCOUNT_W-1:0]  cfg_data_i
);

  import vmlv_pkg::*;

  // one memory row holds the whole histogram of one vertex
  localparam int unsigned RowW    = LABEL_COUNT * COUNT_BITS;
  localparam int unsigned AW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned LW      = $clog2(LABEL_COUNT);
  localparam int unsigned IdExtW  = (AW > ID_W) ? AW : ID_W;
  localparam int unsigned MaxLimW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CmpW    = (MaxLimW > ID_W) ? MaxLimW : ID_W;
  localparam int unsigned LblCmpW = LABEL_IN_W + 1;

  localparam logic [CmpW-1:0]    MaxVert  = CmpW'(MAX_VERTICES);
  localparam logic [LblCmpW-1:0] LabelLim = LblCmpW'(LABEL_COUNT);
  localparam logic [AW-1:0]      LastRow  = AW'(MAX_VERTICES - 1);
  localparam logic [STEP_W-1:0]  LastStep = STEP_W'(TRI_CORNERS - 1);

  // an id counts only below both the configured count and the memory depth
  function automatic logic id_ok(input logic [ID_W-1:0] id,
                                 input logic [VCOUNT_W-1:0] cnt);
    id_ok = (VCOUNT_W'(id) < cnt) && (CmpW'(id) < MaxVert);
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [ID_W-1:0] id);
    logic [IdExtW-1:0] ext;
    ext     = IdExtW'(id);
    to_addr = ext[AW-1:0];
  endfunction

  vmlv_state_e state_q, state_d;

  logic [STEP_W-1:0]   step_q, step_d;
  logic [AW-1:0]       clr_ptr_q, clr_ptr_d;
  logic                clr_pend_q, clr_pend_d;
  logic                error_q, error_d;
  logic                res_stb_q, res_stb_d;
  logic                res_acc_q, res_acc_d;
  logic [VLABEL_W-1:0] res_lbl_q, res_lbl_d;
  logic [VCOUNT_W-1:0] vert_cnt_q;

  // corner addresses of the triangle in flight, shifted one place per step
  logic [AW-1:0]       addr0_q, addr1_q, addr2_q;
  logic [LW-1:0]       label_q;

  // same-cycle write forwarding into the registered read path
  logic                fwd_hit_q;
  logic [RowW-1:0]     fwd_data_q;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [RowW-1:0]     ram_wdata;
  logic [RowW-1:0]     ram_rdata;
  logic [RowW-1:0]     row_rd;
  logic [RowW-1:0]     row_upd;

  logic                tri_ok;
  logic                tri_load;
  logic                tri_shift;
  logic                scan_load;
  logic                scan_done;
  logic [LW-1:0]       scan_label;
  logic                item_accept;

  assign item_accept = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign tri_ok = ({1'b0, part_label_i} < LabelLim)
               && id_ok(vertex_a_i, vert_cnt_q)
               && id_ok(vertex_b_i, vert_cnt_q)
               && id_ok(vertex_c_i, vert_cnt_q);

  assign row_rd = fwd_hit_q ? fwd_data_q : ram_rdata;

  vmlv_row_ram #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (RowW),
    .AW    (AW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vmlv_row_update #(
    .LABEL_COUNT (LABEL_COUNT),
    .COUNT_BITS  (COUNT_BITS),
    .LW          (LW)
  ) u_row_update (
    .row_i   (row_rd),
    .label_i (label_q),
    .row_o   (row_upd)
  );

  vmlv_vote_scan #(
    .LABEL_COUNT (LABEL_COUNT),
    .COUNT_BITS  (COUNT_BITS),
    .LW          (LW)
  ) u_vote_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (scan_load),
    .row_i   (row_rd),
    .done_o  (scan_done),
    .label_o (scan_label)
  );

  // next state and control
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    clr_ptr_d  = clr_ptr_q;
    clr_pend_d = clr_pend_q;
    error_d    = error_q;
    res_stb_d  = 1'b0;
    res_acc_d  = 1'b0;
    res_lbl_d  = '0;
    ram_we     = 1'b0;
    ram_waddr  = addr0_q;
    ram_wdata  = row_upd;
    ram_raddr  = addr1_q;
    tri_load   = 1'b0;
    tri_shift  = 1'b0;
    scan_load  = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // zero one row per cycle
        ram_we    = 1'b1;
        ram_waddr = clr_ptr_q;
        ram_wdata = '0;
        if (clr_ptr_q == LastRow) begin
          state_d = ST_IDLE;
          if (clr_pend_q) begin
            res_stb_d  = 1'b1;
            res_acc_d  = 1'b1;
            clr_pend_d = 1'b0;
          end
        end else begin
          clr_ptr_d = clr_ptr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        // first read goes out in the cycle the item is taken
        ram_raddr = (req_type_i == REQ_QUERY) ? to_addr(query_vertex_i)
                                              : to_addr(vertex_a_i);
        if (item_accept) begin
          case (req_type_i)
            REQ_ADD: begin
              if (tri_ok) begin
                tri_load = 1'b1;
                step_d   = '0;
                state_d  = ST_TRI;
              end else begin
                error_d   = 1'b1;
                res_stb_d = 1'b1;
              end
            end
            REQ_QUERY: begin
              if (id_ok(query_vertex_i, vert_cnt_q)) begin
                state_d = ST_QLOAD;
              end else begin
                res_stb_d = 1'b1;
              end
            end
            REQ_CLEAR: begin
              error_d    = 1'b0;
              clr_pend_d = 1'b1;
              clr_ptr_d  = '0;
              state_d    = ST_CLEAR;
            end
            default: begin
              res_stb_d = 1'b1;
            end
          endcase
        end
      end
      ST_TRI: begin
        // write back the current corner, read the next one
        ram_we    = 1'b1;
        tri_shift = 1'b1;
        if (step_q == LastStep) begin
          state_d   = ST_IDLE;
          res_stb_d = 1'b1;
          res_acc_d = 1'b1;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_QLOAD: begin
        scan_load = 1'b1;
        state_d   = ST_QSCAN;
      end
      ST_QSCAN: begin
        if (scan_done) begin
          state_d   = ST_IDLE;
          res_stb_d = 1'b1;
          res_acc_d = 1'b1;
          res_lbl_d = VLABEL_W'(scan_label);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      step_q     <= '0;
      clr_ptr_q  <= '0;
      clr_pend_q <= 1'b0;
      error_q    <= 1'b0;
      res_stb_q  <= 1'b0;
      vert_cnt_q <= VCOUNT_RESET;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      clr_ptr_q  <= clr_ptr_d;
      clr_pend_q <= clr_pend_d;
      error_q    <= error_d;
      res_stb_q  <= res_stb_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vert_cnt_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_acc_q  <= res_acc_d;
    res_lbl_q  <= res_lbl_d;
    fwd_hit_q  <= ram_we && (ram_waddr == ram_raddr);
    fwd_data_q <= ram_wdata;
    if (tri_load) begin
      addr0_q <= to_addr(vertex_a_i);
      addr1_q <= to_addr(vertex_b_i);
      addr2_q <= to_addr(vertex_c_i);
      label_q <= part_label_i[LW-1:0];
    end else if (tri_shift) begin
      addr0_q <= addr1_q;
      addr1_q <= addr2_q;
    end
  end

  assign result_strobe_o = res_stb_q;
  assign accepted_o      = res_acc_q;
  assign error_seen_o    = error_q;
  assign vertex_label_o  = res_lbl_q;

  // a counted triangle is reported by an accepted result beat
  a_tri_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_accept && (req_type_i == REQ_ADD) && tri_ok |=> ##3 (res_stb_q && res_acc_q))
    else $error("triangle result not on time");

  // results only appear once the sequencer is back at rest
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_stb_q |-> (state_q == ST_IDLE))
    else $error("result strobe outside idle");

  // the sticky flag is only ever raised by a rejected triangle
  a_err_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(error_q) |-> $past(item_accept && (req_type_i == REQ_ADD) && !tri_ok))
    else $error("error flag set without a rejected triangle");

  // the scan unit finishes only while a query waits for it
  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> (state_q == ST_QSCAN))
    else $error("scan finished outside a query");

endmodule

`default_nettype wire

// ===== tb/label_vote_check_pkg.sv =====
// scoreboard for the vertex majority label vote testbench: histogram predictor and result queue
// depends on vmlv_pkg for the request codes and field widths
`timescale 1ns / 100ps

package label_vote_check_pkg;
  import vmlv_pkg::*;

  localparam int unsigned MAX_VERTICES = 4096;
  localparam int unsigned LABEL_COUNT  = 16;
  localparam int unsigned COUNT_BITS   = 16;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned REPORT_CAP = 30;

  typedef struct packed {
    logic                accepted;
    logic                error_seen;
    logic [VLABEL_W-1:0] vertex_label;
  } vote_result_t;

  class label_vote_scoreboard;
    logic [COUNT_BITS-1:0] hist [MAX_VERTICES*LABEL_COUNT];
    logic                  error_flag;
    int unsigned           vert_cnt;
    vote_result_t          expected_votes [$];
    int unsigned           errors;
    int unsigned           checked;

    function new();
      wipe();
      vert_cnt = VCOUNT_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void wipe();
      foreach (hist[i]) hist[i] = '0;
      error_flag = 1'b0;
    endfunction

    function int unsigned vertex_limit();
      return (vert_cnt < MAX_VERTICES) ? vert_cnt : MAX_VERTICES;
    endfunction

    function void set_vert_cnt(logic [VCOUNT_W-1:0] value);
      vert_cnt = value;
    endfunction

    // highest count wins, the strict compare keeps the lowest label on a tie
    function logic [VLABEL_W-1:0] top_label(int unsigned v);
      int unsigned           best;
      logic [COUNT_BITS-1:0] best_count;
      best = 0;
      best_count = hist[v*LABEL_COUNT];
      for (int unsigned l = 1; l < LABEL_COUNT; l++) begin
        if (hist[v*LABEL_COUNT + l] > best_count) begin
          best_count = hist[v*LABEL_COUNT + l];
          best = l;
        end
      end
      return best[VLABEL_W-1:0];
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                               logic [ID_W-1:0] c, logic [LABEL_IN_W-1:0] label,
                               logic [ID_W-1:0] qv);
      vote_result_t    res;
      int unsigned     lim;
      int unsigned     idx;
      logic [ID_W-1:0] corners [TRI_CORNERS];
      res = '0;
      lim = vertex_limit();
      corners = '{a, b, c};
      case (req)
        REQ_ADD: begin
          if (label < LABEL_COUNT && a < lim && b < lim && c < lim) begin
            // a repeated corner counts once per occurrence
            foreach (corners[i]) begin
              idx = corners[i] * LABEL_COUNT + label;
              if (hist[idx] != '1) hist[idx] = hist[idx] + 1'b1;
            end
            res.accepted = 1'b1;
          end else begin
            error_flag = 1'b1;
          end
        end
        REQ_QUERY: begin
          if (qv < lim) begin
            res.vertex_label = top_label(qv);
            res.accepted = 1'b1;
          end
        end
        REQ_CLEAR: begin
          wipe();
          res.accepted = 1'b1;
        end
        default: ;
      endcase
      res.error_seen = error_flag;
      expected_votes = {expected_votes, res};
    endfunction

    function void compare(string field, logic [VLABEL_W-1:0] want, logic [VLABEL_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch on result %0d, expected %0d, got %0d",
                   $time, field, checked, want, got);
      end
    endfunction

    function void check_result(logic acc, logic err, logic [VLABEL_W-1:0] vl);
      vote_result_t want;
      if (expected_votes.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result beat with nothing expected, accepted %0d error_seen %0d label %0d",
                   $time, acc, err, vl);
        return;
      end
      want = expected_votes.pop_front();
      checked++;
      compare("accepted", VLABEL_W'(want.accepted), VLABEL_W'(acc));
      compare("error_seen", VLABEL_W'(want.error_seen), VLABEL_W'(err));
      compare("vertex_label", want.vertex_label, vl);
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// testbench top for vertex_majority_label_vote: directed and random request beats
// depends on vmlv_pkg, label_vote_check_pkg and the block's rtl
`timescale 1ns / 100ps

module testbench;
  import vmlv_pkg::*;
  import label_vote_check_pkg::*;

  // watchdog limit on the run; clear sweeps dominate its length, then queries
  localparam int unsigned CYCLE_LIMIT     = 1_500_000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 62;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [REQ_W-1:0]      req_type_i = '0;
  logic [ID_W-1:0]       vertex_a_i = '0;
  logic [ID_W-1:0]       vertex_b_i = '0;
  logic [ID_W-1:0]       vertex_c_i = '0;
  logic [LABEL_IN_W-1:0] part_label_i = '0;
  logic [ID_W-1:0]       query_vertex_i = '0;
  logic                  result_strobe_o;
  logic                  accepted_o;
  logic                  error_seen_o;
  logic [VLABEL_W-1:0]   vertex_label_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [VCOUNT_W-1:0]   cfg_data_i = '0;

  label_vote_scoreboard sb = new();

  int unsigned cycles = 0;
  int unsigned n_tri = 0;
  int unsigned n_query = 0;
  int unsigned n_clear = 0;
  int unsigned n_unused = 0;

  vertex_majority_label_vote #(
    .MAX_VERTICES(MAX_VERTICES),
    .LABEL_COUNT (LABEL_COUNT),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .vertex_c_i     (vertex_c_i),
    .part_label_i   (part_label_i),
    .query_vertex_i (query_vertex_i),
    .result_strobe_o(result_strobe_o),
    .accepted_o     (accepted_o),
    .error_seen_o   (error_seen_o),
    .vertex_label_o (vertex_label_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, sb.expected_votes.size());
      $display("FAILURE");
      $finish;
    end
  end

  // result beats last one cycle and cannot be held off, so sample every edge
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o)
      sb.check_result(accepted_o, error_seen_o, vertex_label_o);
  end

  // one request beat; start stays high on return so back-to-back beats need no gap
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] a,
                           input logic [ID_W-1:0] b, input logic [ID_W-1:0] c,
                           input logic [LABEL_IN_W-1:0] label, input logic [ID_W-1:0] qv);
    start          <= 1'b1;
    req_type_i     <= req;
    vertex_a_i     <= a;
    vertex_b_i     <= b;
    vertex_c_i     <= c;
    part_label_i   <= label;
    query_vertex_i <= qv;
    do @(posedge clk_i); while (busy);
    sb.note_request(req, a, b, c, label, qv);
    case (req)
      REQ_ADD:   n_tri++;
      REQ_QUERY: n_query++;
      REQ_CLEAR: n_clear++;
      default:   n_unused++;
    endcase
  endtask

  // fields a request ignores still carry random bits
  task automatic add_tri(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                         input logic [ID_W-1:0] c, input logic [LABEL_IN_W-1:0] label);
    send_item(REQ_ADD, a, b, c, label, ID_W'($urandom));
  endtask

  task automatic ask_vertex(input logic [ID_W-1:0] v);
    send_item(REQ_QUERY, ID_W'($urandom), ID_W'($urandom), ID_W'($urandom),
              LABEL_IN_W'($urandom), v);
  endtask

  task automatic clear_all();
    send_item(REQ_CLEAR, ID_W'($urandom), ID_W'($urandom), ID_W'($urandom),
              LABEL_IN_W'($urandom), ID_W'($urandom));
  endtask

  task automatic idle(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // hold off until every expected beat is back and the block has dropped busy
  task automatic settle(input int unsigned tail);
    start <= 1'b0;
    while (sb.expected_votes.size() != 0 || busy) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_vert_cnt(input logic [VCOUNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_vert_cnt(value);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly a few hot vertices and the top of the range, so counts pile up and ties occur
  function automatic logic [ID_W-1:0] pick_vertex();
    int unsigned lim;
    int unsigned r;
    lim = sb.vertex_limit();
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 10) return ID_W'($urandom);
    if (r < 55) return ID_W'($urandom_range(0, ((lim < 6) ? lim : 6) - 1));
    if (r < 75) return ID_W'(lim - 1 - $urandom_range(0, ((lim < 4) ? lim : 4) - 1));
    return ID_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic random_item();
    int unsigned           sel;
    logic [ID_W-1:0]       a;
    logic [ID_W-1:0]       b;
    logic [ID_W-1:0]       c;
    logic [ID_W-1:0]       qv;
    logic [LABEL_IN_W-1:0] label;
    sel = $urandom_range(0, 99);
    a = pick_vertex();
    b = pick_vertex();
    c = pick_vertex();
    qv = pick_vertex();
    label = ($urandom_range(0, 9) == 0) ? LABEL_IN_W'($urandom)
                                        : LABEL_IN_W'($urandom_range(0, LABEL_COUNT - 1));
    if (sel < 55)
      send_item(REQ_ADD, a, b, c, label, qv);
    else if (sel < 88)
      send_item(REQ_QUERY, a, b, c, label, qv);
    else if (sel < 90)
      clear_all();
    else if (sel < 94)
      send_item(REQ_UNUSED, a, b, c, label, qv);
    else
      // noise triangle, any bit pattern at all
      send_item(REQ_ADD, ID_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                LABEL_IN_W'($urandom), qv);
  endtask

  // sender gaps come in bursts, switched on and off every sixteen beats
  task automatic run_phase(input int unsigned items, input bit with_gaps);
    int unsigned idle_pct;
    idle_pct = 0;
    for (int unsigned n = 0; n < items; n++) begin
      if (n % 16 == 0) idle_pct = (with_gaps && $urandom_range(0, 2) != 0) ? 30 : 0;
      random_item();
      if ($urandom_range(0, 99) < idle_pct) idle($urandom_range(1, 15));
    end
  endtask

  initial begin
    int unsigned phase_counts [PHASES];
    phase_counts = '{4096, 2, 4095, 8191, 1, 100, 0, 4096};
    phase_counts[1] = $urandom_range(2, 64);
    phase_counts[5] = $urandom_range(65, 4094);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // the block sweeps its row memory after reset with busy high
    settle(4);

    // directed: empty vertex, id and label extremes, rejects, tie, unused code, clear
    write_vert_cnt(VCOUNT_RESET);
    ask_vertex(12'd0);
    add_tri(12'd0, 12'd0, 12'd0, 8'd0);
    add_tri(12'd4095, 12'd4095, 12'd0, 8'd15);
    add_tri(12'd1, 12'd2, 12'd3, 8'd16);
    add_tri(12'd1, 12'd2, 12'd3, 8'd255);
    ask_vertex(12'd4095);
    ask_vertex(12'd0);
    // vertex 5 ends with labels 3 and 7 both at two, label 3 must win
    add_tri(12'd5, 12'd5, 12'd6, 8'd7);
    add_tri(12'd5, 12'd6, 12'd6, 8'd3);
    add_tri(12'd5, 12'd9, 12'd9, 8'd3);
    ask_vertex(12'd5);
    send_item(REQ_UNUSED, '1, '1, '1, '1, '1);
    clear_all();
    ask_vertex(12'd4095);
    send_item(REQ_UNUSED, '0, '0, '0, '0, '0);

    // a single vertex in use
    settle(4);
    write_vert_cnt(13'd1);
    add_tri(12'd0, 12'd0, 12'd0, 8'd4);
    add_tri(12'd0, 12'd1, 12'd0, 8'd4);
    ask_vertex(12'd1);
    ask_vertex(12'd0);

    // no vertices at all: every triangle rejected, every query fails
    settle(4);
    write_vert_cnt(13'd0);
    add_tri(12'd0, 12'd0, 12'd0, 8'd0);
    ask_vertex(12'd0);

    // count above the memory size is capped at the memory size
    settle(4);
    write_vert_cnt('1);
    add_tri(12'd4095, 12'd2048, 12'd1, 8'd8);
    ask_vertex(12'd4095);

    // random phases over several vertex counts, the last one without gaps
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle(4);
      write_vert_cnt(VCOUNT_W'(phase_counts[p]));
      run_phase(ITEMS_PER_PHASE, p != PHASES - 1);
    end

    // drain, then allow a query's latency and more for any stray beat
    settle(40);

    $display("%0d beats sent: %0d triangles, %0d queries, %0d clears, %0d unused; %0d results checked",
             n_tri + n_query + n_clear + n_unused, n_tri, n_query, n_clear, n_unused, sb.checked);
    $display("vertex counts 0, 1, 4095, 4096, 8191, %0d and %0d; ties and rejects included",
             phase_counts[1], phase_counts[5]);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
